// ----- hw/rtl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the random generator RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication property on the rising clock edge, outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds on the rising clock edge, outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_PROP(lbl, clk, rst, !(cond), msg)

`endif

// ----- hw/rtl/pcg_pkg.sv -----
// -----------------------------------------------------------------------------
// PCG generator package
// Widths, reset values, register indexes and shared types.
// -----------------------------------------------------------------------------
package pcg_pkg;

   localparam int unsigned WORD_WIDTH      = 64;
   localparam int unsigned HALF_WIDTH      = 32;
   localparam int unsigned OUT_WIDTH       = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   localparam logic [WORD_WIDTH-1:0] RESET_STATE      = 64'h853c_49e6_748f_ea9b;
   localparam logic [WORD_WIDTH-1:0] RESET_INCREMENT  = 64'hda3e_39cb_94b9_5bdb;
   localparam logic [WORD_WIDTH-1:0] RESET_MULTIPLIER = 64'd6364136223846793005;
   localparam logic [WORD_WIDTH-1:0] RESET_OFFSET     = 64'd9600629759793949339;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MULTIPLIER   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_OFFSET = 1'd1;

   localparam logic KIND_DRAW   = 1'b0;
   localparam logic KIND_RESEED = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } lcg_status_type;

endpackage

// ----- hw/rtl/pcg_req_if.sv -----
// -----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one draw or reseed request.
// -----------------------------------------------------------------------------
interface pcg_req_if;

   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [pcg_pkg::WORD_WIDTH-1:0]  sequence_index;

   modport source (output valid, output kind, output sequence_index, input ready);
   modport sink   (input valid, input kind, input sequence_index, output ready);

endinterface

// ----- hw/rtl/pcg_rsp_if.sv -----
// -----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one random word.
// -----------------------------------------------------------------------------
interface pcg_rsp_if;

   logic                           valid;
   logic                           ready;
   logic [pcg_pkg::OUT_WIDTH-1:0]  random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);

endinterface

// ----- hw/rtl/pcg_lcg_unit.sv -----
// -----------------------------------------------------------------------------
// LCG advance unit
// Computes state * multiplier + increment modulo 2^64 on one shared 32x32
// multiplier through the low, cross-B, cross-A and finish steps.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcg_lcg_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pcg_pkg::WORD_WIDTH-1:0]  state_value,
   input  logic [pcg_pkg::WORD_WIDTH-1:0]  mult_value,
   input  logic [pcg_pkg::WORD_WIDTH-1:0]  inc_value,
   output pcg_pkg::lcg_status_type         status,
   output logic [pcg_pkg::WORD_WIDTH-1:0]  next_state
);

   localparam logic [1:0] STEP_LOW     = 2'd0;
   localparam logic [1:0] STEP_CROSS_B = 2'd1;
   localparam logic [1:0] STEP_CROSS_A = 2'd2;
   localparam logic [1:0] STEP_FINISH  = 2'd3;

   localparam int unsigned HW = pcg_pkg::HALF_WIDTH;
   localparam int unsigned WW = pcg_pkg::WORD_WIDTH;

   logic          busy_ff, busy_in;
   logic [1:0]    step_ff, step_in;
   logic [WW-1:0] prod_ff, prod_in;
   logic [WW-1:0] acc_ff, acc_in;
   logic [1:0]    phase;
   logic [HW-1:0] op_a;
   logic [HW-1:0] op_b;
   logic [WW-1:0] prod_shifted;

   assign phase        = busy_ff ? step_ff : STEP_LOW;
   assign op_a         = (phase == STEP_CROSS_A) ? state_value[WW-1:HW] : state_value[HW-1:0];
   assign op_b         = (phase == STEP_CROSS_B) ? mult_value[WW-1:HW] : mult_value[HW-1:0];
   assign prod_shifted = {prod_ff[HW-1:0], {HW{1'b0}}};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      prod_in = WW'(op_a) * WW'(op_b);
      acc_in  = acc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = STEP_CROSS_B;
         end
      end else begin
         case (step_ff)
            STEP_CROSS_B: acc_in = prod_ff + inc_value;
            STEP_CROSS_A: acc_in = acc_ff + prod_shifted;
            default:      acc_in = acc_ff;
         endcase
         if (step_ff == STEP_FINISH) begin
            busy_in = 1'b0;
            step_in = STEP_LOW;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_LOW;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = busy_ff && (step_ff == STEP_FINISH);
   assign next_state  = acc_ff + prod_shifted;

   `ASSERT_PROP(a_done_after_run, clock, reset, status.done |-> $past(busy_ff, 2),
      "done without a full run")
   `ASSERT_PROP(a_start_runs, clock, reset, (start && !busy_ff) |=> busy_ff,
      "start did not begin a run")
   `ASSERT_NEVER(a_idle_step, clock, reset, !busy_ff && (step_ff != STEP_LOW),
      "idle unit left a step count")

endmodule

// ----- hw/rtl/pcg32_random_generator.sv -----
// -----------------------------------------------------------------------------
// PCG32 random generator
// A draw request returns one XSH-RR word of the current state and advances
// the state; a reseed request selects a new stream and returns nothing. A
// draw or reseed keeps the block busy until its state advance is done; every
// state advance runs four steps on one shared 32x32 multiplier. A request
// is taken only when the block is idle and the response slot is free or
// being emptied in the same cycle. The user must write registers through
// the csr port only while the block is idle; the block does not enforce it.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcg32_random_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   pcg_req_if.sink                               req_chan,
   pcg_rsp_if.source                             rsp_chan,
   input  logic                                  csr_we,
   input  logic [pcg_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pcg_pkg::WORD_WIDTH-1:0]        csr_wdata
);

   localparam int unsigned WW = pcg_pkg::WORD_WIDTH;
   localparam int unsigned OW = pcg_pkg::OUT_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEED,
      ST_ADVANCE
   } fsm_type;

   fsm_type       fsm_ff, fsm_in;
   logic [WW-1:0] state_ff, state_in;
   logic [WW-1:0] inc_ff, inc_in;
   logic [WW-1:0] mult_ff, mult_in;
   logic [WW-1:0] offset_ff, offset_in;
   logic [OW-1:0] word_ff, word_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic                    req_fire;
   logic                    unit_start;
   logic [WW-1:0]           unit_next;
   pcg_pkg::lcg_status_type unit_status;

   function automatic logic [OW-1:0] permute(input logic [WW-1:0] old);
      logic [WW-1:0]   mixed;
      logic [OW-1:0]   xs;
      logic [4:0]      rot;
      logic [2*OW-1:0] doubled;
      mixed   = (old >> 18) ^ old;
      xs      = mixed[58:27];
      rot     = old[63:59];
      doubled = {xs, xs} >> rot;
      return doubled[OW-1:0];
   endfunction

   assign req_chan.ready   = (fsm_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.random_word = word_ff;

   always_comb begin
      fsm_in       = fsm_ff;
      state_in     = state_ff;
      inc_in       = inc_ff;
      mult_in      = mult_ff;
      offset_in    = offset_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unit_start   = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            pcg_pkg::CSR_MULTIPLIER:   mult_in   = csr_wdata;
            pcg_pkg::CSR_START_OFFSET: offset_in = csr_wdata;
            default:                   mult_in   = mult_ff;
         endcase
      end

      unique case (fsm_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind == pcg_pkg::KIND_DRAW) begin
                  word_in      = permute(state_ff);
                  rsp_valid_in = 1'b1;
                  unit_start   = 1'b1;
                  fsm_in       = ST_ADVANCE;
               end else begin
                  inc_in   = {req_chan.sequence_index[WW-2:0], 1'b1};
                  state_in = {req_chan.sequence_index[WW-2:0], 1'b1} + offset_ff;
                  fsm_in   = ST_SEED;
               end
            end
         end
         ST_SEED: begin
            unit_start = 1'b1;
            fsm_in     = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            if (unit_status.done) begin
               state_in = unit_next;
               fsm_in   = ST_IDLE;
            end
         end
         default: fsm_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         state_ff     <= pcg_pkg::RESET_STATE;
         inc_ff       <= pcg_pkg::RESET_INCREMENT;
         mult_ff      <= pcg_pkg::RESET_MULTIPLIER;
         offset_ff    <= pcg_pkg::RESET_OFFSET;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         inc_ff       <= inc_in;
         mult_ff      <= mult_in;
         offset_ff    <= offset_in;
      end
   end

   pcg_lcg_unit u_lcg (
      .clock       (clock),
      .reset       (reset),
      .start       (unit_start),
      .state_value (state_ff),
      .mult_value  (mult_ff),
      .inc_value   (inc_ff),
      .status      (unit_status),
      .next_state  (unit_next)
   );

   `ASSERT_PROP(a_done_in_advance, clock, reset, unit_status.done |-> (fsm_ff == ST_ADVANCE), "advance finished outside ADVANCE")
   `ASSERT_PROP(a_draw_gives_word, clock, reset, (req_fire && (req_chan.kind == pcg_pkg::KIND_DRAW)) |=> rsp_valid_ff, "draw transfer left no response")
   `ASSERT_NEVER(a_start_while_busy, clock, reset, unit_start && unit_status.busy, "advance started while the unit was busy")
   `ASSERT_PROP(a_seed_starts_unit, clock, reset, (fsm_ff == ST_SEED) |=> unit_status.busy, "reseed did not start an advance")

endmodule

// ----- tb/tb_pcg32_random_generator.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// PCG32 random generator testbench
// Sends draw and reseed requests with bursty timing while the response side
// stalls in several patterns. Every returned word is checked against a local
// XSH-RR predictor. A short directed table covers the register extremes, the
// dropped top bit of the stream index and the zero multiplier. Random phases
// follow, each first writing a multiplier and a start offset.
// -----------------------------------------------------------------------------
module tb_pcg32_random_generator;

   localparam int unsigned WW = pcg_pkg::WORD_WIDTH;
   localparam int unsigned OW = pcg_pkg::OUT_WIDTH;
   localparam int unsigned IW = pcg_pkg::CSR_INDEX_WIDTH;

   localparam int unsigned LIMIT_CYCLES   = 500000;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned PHASE_COUNT    = 6;
   localparam int unsigned PHASE_REQUESTS = 300;
   localparam logic [WW-1:0] ALL_ONES = {WW{1'b1}};
   localparam logic [WW-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;

   typedef enum logic [1:0] {
      ROW_DRAW,
      ROW_RESEED,
      ROW_WRITE
   } row_op_type;

   typedef struct {
      row_op_type     op;
      logic [IW-1:0]  csr;
      logic [WW-1:0]  value;
      bit             has_word;
      logic [OW-1:0]  word;
   } stim_row_type;

   logic           clock;
   logic           reset;
   logic           csr_we;
   logic [IW-1:0]  csr_index;
   logic [WW-1:0]  csr_wdata;

   pcg_req_if req_bus ();
   pcg_rsp_if rsp_bus ();

   pcg32_random_generator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [WW-1:0]  lcg_state;
   logic [WW-1:0]  stream_inc;
   logic [WW-1:0]  mult_reg;
   logic [WW-1:0]  offset_reg;
   logic [OW-1:0]  expected_words[$];
   stim_row_type   stimulus_table[$];
   int unsigned    error_count;
   int unsigned    cycle_count;
   int unsigned    burst_left;
   int unsigned    rx_mode;
   int unsigned    rx_count;
   int unsigned    rx_hold;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [OW-1:0] xsh_rr_word(input logic [WW-1:0] old);
      logic [OW-1:0]    xs;
      logic [4:0]       rot;
      logic [2*OW-1:0]  doubled;
      xs = OW'(((old >> 18) ^ old) >> 27);
      rot = old[63:59];
      doubled = {xs, xs} >> rot;
      return doubled[OW-1:0];
   endfunction

   function automatic logic [WW-1:0] lcg_step(input logic [WW-1:0] s);
      return s * mult_reg + stream_inc;
   endfunction

   function automatic void add_row(input row_op_type op, input logic [IW-1:0] csr,
                                   input logic [WW-1:0] value, input bit has_word,
                                   input logic [OW-1:0] word);
      stim_row_type row;
      row.op = op;
      row.csr = csr;
      row.value = value;
      row.has_word = has_word;
      row.word = word;
      stimulus_table.push_back(row);
   endfunction

   // Advances the local generator for one accepted request.
   function automatic void predict_request(input logic kind, input logic [WW-1:0] index,
                                           input bit has_word, input logic [OW-1:0] word);
      logic [OW-1:0] predicted;
      if (kind == pcg_pkg::KIND_DRAW) begin
         predicted = xsh_rr_word(lcg_state);
         lcg_state = lcg_step(lcg_state);
         expected_words.push_back(has_word ? word : predicted);
      end else begin
         stream_inc = {index[WW-2:0], 1'b1};
         lcg_state = lcg_step('0);
         lcg_state = lcg_state + offset_reg;
         lcg_state = lcg_step(lcg_state);
      end
   endfunction

   task automatic sender_gap(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         req_bus.kind <= 1'($urandom_range(0, 1));
         req_bus.sequence_index <= {$urandom, $urandom};
      end
   endtask

   task automatic send_request(input logic kind, input logic [WW-1:0] index,
                               input bit has_word, input logic [OW-1:0] word);
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.kind <= kind;
      req_bus.sequence_index <= index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_request(kind, index, has_word, word);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            sender_gap(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8));
         end
      end
   endtask

   // Leaves the block idle: no request pending, every word back, reseeds done.
   task automatic settle_block();
      sender_gap(1);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [IW-1:0] index, input logic [WW-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      csr_wdata <= {$urandom, $urandom};
      if (index == pcg_pkg::CSR_MULTIPLIER) mult_reg = value;
      else if (index == pcg_pkg::CSR_START_OFFSET) offset_reg = value;
   endtask

   always @(negedge clock) begin
      rx_count <= rx_count + 1;
      case (rx_mode)
         0: begin
            rsp_bus.ready <= 1'b1;
         end
         1: begin
            rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_bus.ready <= ((rx_count % 7) >= 3);
         end
         default: begin
            if (rx_hold > 0) begin
               rx_hold <= rx_hold - 1;
               rsp_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               rx_hold <= $urandom_range(5, 12);
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      endcase
   end

   always @(posedge clock) begin : check_words
      logic [OW-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected random_word transfer, expected none, actual %h",
                     $time, rsp_bus.random_word);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_bus.random_word !== want) begin
               $display("%0t: random_word mismatch, expected %h, actual %h",
                        $time, want, rsp_bus.random_word);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [WW-1:0]  index;
      logic [WW-1:0]  new_mult;
      logic [WW-1:0]  new_offset;
      logic           kind;
      stim_row_type   row;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = pcg_pkg::CSR_MULTIPLIER;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = pcg_pkg::KIND_DRAW;
      req_bus.sequence_index = '0;
      rsp_bus.ready = 1'b0;
      error_count = 0;
      cycle_count = 0;
      rx_count = 0;
      rx_hold = 0;
      rx_mode = $urandom_range(0, 3);
      burst_left = $urandom_range(1, 16);
      lcg_state = pcg_pkg::RESET_STATE;
      stream_inc = pcg_pkg::RESET_INCREMENT;
      mult_reg = pcg_pkg::RESET_MULTIPLIER;
      offset_reg = pcg_pkg::RESET_OFFSET;

      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   ALL_ONES, 0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      add_row(ROW_RESEED, pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      add_row(ROW_RESEED, pcg_pkg::CSR_MULTIPLIER,   ALL_ONES, 0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      // With a zero multiplier the state settles on the increment.
      add_row(ROW_WRITE,  pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      add_row(ROW_WRITE,  pcg_pkg::CSR_START_OFFSET, ALL_ONES, 0, '0);
      add_row(ROW_RESEED, pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       1, 32'h0000_0000);
      add_row(ROW_RESEED, pcg_pkg::CSR_MULTIPLIER,   64'h0400_0000, 0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       1, 32'h0000_0001);
      add_row(ROW_RESEED, pcg_pkg::CSR_MULTIPLIER,   TOP_BIT | 64'h0400_0000, 0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       1, 32'h0000_0001);
      add_row(ROW_RESEED, pcg_pkg::CSR_MULTIPLIER,   64'h4000_0000_0000_0000, 0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       1, 32'h0000_0004);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   ALL_ONES, 1, 32'h0000_0004);
      add_row(ROW_WRITE,  pcg_pkg::CSR_MULTIPLIER,   ALL_ONES, 0, '0);
      add_row(ROW_WRITE,  pcg_pkg::CSR_START_OFFSET, '0,       0, '0);
      add_row(ROW_RESEED, pcg_pkg::CSR_MULTIPLIER,   ALL_ONES, 0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      add_row(ROW_WRITE,  pcg_pkg::CSR_MULTIPLIER,   64'd1,    0, '0);
      add_row(ROW_WRITE,  pcg_pkg::CSR_START_OFFSET, ALL_ONES, 0, '0);
      add_row(ROW_RESEED, pcg_pkg::CSR_MULTIPLIER,   TOP_BIT,  0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      add_row(ROW_WRITE,  pcg_pkg::CSR_MULTIPLIER,   pcg_pkg::RESET_MULTIPLIER, 0, '0);
      add_row(ROW_WRITE,  pcg_pkg::CSR_START_OFFSET, pcg_pkg::RESET_OFFSET,     0, '0);
      add_row(ROW_RESEED, pcg_pkg::CSR_MULTIPLIER,   64'd54,   0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);
      add_row(ROW_DRAW,   pcg_pkg::CSR_MULTIPLIER,   '0,       0, '0);

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (stimulus_table[i]) begin
         row = stimulus_table[i];
         case (row.op)
            ROW_WRITE: begin
               settle_block();
               write_register(row.csr, row.value);
            end
            ROW_RESEED: begin
               send_request(pcg_pkg::KIND_RESEED, row.value, 0, '0);
            end
            default: begin
               send_request(pcg_pkg::KIND_DRAW, row.value, row.has_word, row.word);
            end
         endcase
      end

      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_block();
         case (phase)
            0: begin
               new_mult = pcg_pkg::RESET_MULTIPLIER;
               new_offset = pcg_pkg::RESET_OFFSET;
            end
            1: begin
               new_mult = '0;
               new_offset = {$urandom, $urandom};
            end
            2: begin
               new_mult = ALL_ONES;
               new_offset = '0;
            end
            3: begin
               new_mult = 64'd1;
               new_offset = ALL_ONES;
            end
            4: begin
               new_mult = {$urandom, $urandom} | 64'd1;
               new_offset = {$urandom, $urandom};
            end
            default: begin
               new_mult = {$urandom, $urandom};
               new_offset = pcg_pkg::RESET_OFFSET;
            end
         endcase
         write_register(pcg_pkg::CSR_MULTIPLIER, new_mult);
         write_register(pcg_pkg::CSR_START_OFFSET, new_offset);
         rx_mode = (phase == 0) ? 0 : $urandom_range(0, 3);
         for (int unsigned n = 0; n < PHASE_REQUESTS; n++) begin
            kind = ($urandom_range(0, 7) == 0) ? pcg_pkg::KIND_RESEED : pcg_pkg::KIND_DRAW;
            case ($urandom_range(0, 11))
               0: index = '0;
               1: index = ALL_ONES;
               2: index = TOP_BIT;
               3: index = ~TOP_BIT;
               default: index = {$urandom, $urandom};
            endcase
            send_request(kind, index, 0, '0);
         end
      end

      settle_block();
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
